[design/hrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrs_pkg
// types, constants and the hash step shared by the reservoir sampler files
// ----------------------------------------------------------------------------
package hrs_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned TAG_BITS_DEF    = 16;

  // fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned SEEN_W  = 32;
  localparam int unsigned CAP_W   = 9;
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [HASH_W-1:0] BASIS_RESET = 64'd1469598103934665603;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_BASIS = 1'b1;

  // input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result kinds
  localparam logic KIND_CAND = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // one fnv-1a step: xor byte, multiply by 2^40 + 0x1b3 modulo 2^64
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] acc,
                                                 input logic [CHAR_W-1:0] ch);
    logic [HASH_W-1:0] x;
    x = acc ^ {{(HASH_W-CHAR_W){1'b0}}, ch};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[design/hrs_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrs_in_if / hrs_out_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface hrs_in_if;
  import hrs_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] id_char;
  logic              id_last;
  logic [TAG_W-1:0]  row_tag;
  logic [SLOT_W-1:0] read_slot;

  modport source (output valid, op, id_char, id_last, row_tag, read_slot, input ready);
  modport sink   (input valid, op, id_char, id_last, row_tag, read_slot, output ready);
endinterface

interface hrs_out_if;
  import hrs_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic              stored;
  logic [SLOT_W-1:0] slot_index;
  logic [TAG_W-1:0]  slot_tag;
  logic [SEEN_W-1:0] seen_total;
  logic [CAP_W-1:0]  fill_count;

  modport source (output valid, kind, stored, slot_index, slot_tag, seen_total, fill_count,
                  input ready);
  modport sink   (input valid, kind, stored, slot_index, slot_tag, seen_total, fill_count,
                  output ready);
endinterface

[design/hrs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hrs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/hrs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrs_div
// bit-serial restoring remainder of a 64-bit hash by the 32-bit seen count
// ----------------------------------------------------------------------------
module hrs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [hrs_pkg::HASH_W-1:0]    dividend_i,
  input  logic [hrs_pkg::SEEN_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [hrs_pkg::SEEN_W-1:0]    rem_o
);
  import hrs_pkg::*;

  localparam int unsigned CNT_W = $clog2(HASH_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [HASH_W-1:0] dvd_q;
  logic [SEEN_W-1:0] div_q;
  logic [SEEN_W-1:0] rem_q;
  logic [SEEN_W:0]   trial;
  logic [SEEN_W:0]   diff;
  logic [SEEN_W-1:0] rem_d;

  // one quotient bit per cycle
  always_comb begin
    trial = {rem_q, dvd_q[HASH_W-1]};
    diff  = trial - {1'b0, div_q};
    rem_d = (trial >= {1'b0, div_q}) ? diff[SEEN_W-1:0] : trial[SEEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(HASH_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("remainder not below divisor");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (busy_q && !done_q))
    else $error("divider did not start");

endmodule

[design/hashed_reservoir_sampler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_reservoir_sampler_core
// deterministic reservoir sampler keyed by a 64-bit fnv-1a identifier hash
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_i      in   valid/ready        op, id_char, id_last, row_tag, read_slot
//  out_o     out  valid/ready        kind, stored, slot_index, slot_tag,
//                                    seen_total, fill_count
//  cfg       in   cfg_we_i           cfg_idx_i, cfg_wdata_i (write only)
//
//  an identifier byte that is not the last is folded into the accumulator at
//  the accepting edge, and the block stays ready for the next byte
//  a last byte passes the decide and output states while appending or with
//  capacity zero; once the store is full, hash mod seen runs between them in
//  the bit-serial remainder unit, one bit per cycle over 64 bits
//  a read goes straight to the output state, which takes the tag from the
//  registered read of the tag ram
//  ready is low while an item is at work and while its result waits for the
//  output register; a stalled output holds the block in the output state
//  reset clears counters, state, capacity and output valid; the tag ram needs
//  no clear, as no tag at or past the fill count is passed on from a read
// ----------------------------------------------------------------------------
module hashed_reservoir_sampler_core #(
  parameter int unsigned MAX_ENTRIES = hrs_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned TAG_BITS    = hrs_pkg::TAG_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  hrs_in_if.sink                          in_i,
  hrs_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [hrs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hrs_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import hrs_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  // stored tag width: the tag field never carries more than TAG_W bits
  localparam int unsigned TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e            state_q;

  // configuration
  logic [CAP_W-1:0]  cap_q;
  logic [HASH_W-1:0] basis_q;

  // sampler state
  logic [HASH_W-1:0] acc_q;
  logic [SEEN_W-1:0] seen_q;
  logic [CAP_W-1:0]  filled_q;

  // item at work
  logic [HASH_W-1:0] hash_q;
  logic [TW-1:0]     tag_q;
  logic              res_kind_q;
  logic              res_stored_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [TAG_W-1:0]  res_tag_q;

  // output register
  logic              out_valid_q;
  logic              out_kind_q;
  logic              out_stored_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [TAG_W-1:0]  out_tag_q;
  logic [SEEN_W-1:0] out_seen_q;
  logic [CAP_W-1:0]  out_fill_q;

  logic              in_fire;
  logic              out_load;
  logic [HASH_W-1:0] hash_d;
  logic [CAP_W-1:0]  eff_cap;
  logic              rd_ok;

  // tag ram ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [TW-1:0]     ram_rdata;

  // remainder unit
  logic              div_start;
  logic              div_done;
  logic [SEEN_W-1:0] div_rem;
  logic              div_keep;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign hash_d   = fnv_step(acc_q, in_i.id_char);

  // capacity above the store depth acts as the store depth
  assign eff_cap = (32'(cap_q) > 32'(MAX_ENTRIES)) ? CAP_W'(MAX_ENTRIES) : cap_q;

  // read hits only filled slots inside the store
  assign rd_ok = ({1'b0, in_i.read_slot} < filled_q) &&
                 (32'(in_i.read_slot) < 32'(MAX_ENTRIES));

  assign div_keep  = (div_rem < 32'(eff_cap));
  assign div_start = (state_q == ST_DECIDE) && (eff_cap != '0) && (filled_q >= eff_cap);

  // write on append, or on replacement once the remainder lands inside capacity
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(filled_q);
    if ((state_q == ST_DECIDE) && (eff_cap != '0) && (filled_q < eff_cap)) begin
      ram_we = 1'b1;
    end else if ((state_q == ST_DIV) && div_done && div_keep) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(div_rem);
    end
  end

  assign ram_re = in_fire && (in_i.op == OP_READ);

  hrs_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tag_q),
    .re_i    (ram_re),
    .raddr_i (AW'(in_i.read_slot)),
    .rdata_o (ram_rdata)
  );

  hrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (hash_q),
    .divisor_i  (seen_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // sequencer, configuration and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= '0;
      basis_q     <= BASIS_RESET;
      acc_q       <= BASIS_RESET;
      seen_q      <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_i.op == OP_READ) begin
              state_q <= ST_OUT;
            end else if (in_i.id_last) begin
              acc_q   <= basis_q;
              if (seen_q != '1) begin
                seen_q <= seen_q + 1'b1;
              end
              state_q <= ST_DECIDE;
            end else begin
              acc_q <= hash_d;
            end
          end
        end
        ST_DECIDE: begin
          if (eff_cap == '0) begin
            state_q <= ST_OUT;
          end else if (filled_q < eff_cap) begin
            filled_q <= filled_q + 1'b1;
            state_q  <= ST_OUT;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // a basis write restarts the hash of a partial identifier
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CAPACITY:   cap_q <= cfg_wdata_i[CAP_W-1:0];
          REG_HASH_BASIS: begin
            basis_q <= cfg_wdata_i;
            acc_q   <= cfg_wdata_i;
          end
          default: ;
        endcase
      end
    end
  end

  // payload of the item at work and of the output register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hash_q     <= hash_d;
      tag_q      <= in_i.row_tag[TW-1:0];
      res_kind_q <= in_i.op;
      res_slot_q <= in_i.read_slot;
      res_stored_q <= (in_i.op == OP_READ) ? rd_ok : 1'b0;
      res_tag_q  <= '0;
    end else if ((state_q == ST_DECIDE) && (eff_cap != '0) && (filled_q < eff_cap)) begin
      res_stored_q <= 1'b1;
      res_slot_q   <= SLOT_W'(filled_q);
      res_tag_q    <= TAG_W'(tag_q);
    end else if (state_q == ST_DECIDE) begin
      res_slot_q <= '0;
    end else if ((state_q == ST_DIV) && div_done && div_keep) begin
      res_stored_q <= 1'b1;
      res_slot_q   <= SLOT_W'(div_rem);
      res_tag_q    <= TAG_W'(tag_q);
    end

    if (out_load) begin
      out_kind_q   <= res_kind_q;
      out_stored_q <= res_stored_q;
      out_slot_q   <= res_slot_q;
      out_seen_q   <= seen_q;
      out_fill_q   <= filled_q;
      if (res_kind_q == KIND_READ) begin
        out_tag_q <= res_stored_q ? TAG_W'(ram_rdata) : '0;
      end else begin
        out_tag_q <= res_tag_q;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.stored     = out_stored_q;
  assign out_o.slot_index = out_slot_q;
  assign out_o.slot_tag   = out_tag_q;
  assign out_o.seen_total = out_seen_q;
  assign out_o.fill_count = out_fill_q;

  a_fill_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(filled_q) <= 32'(MAX_ENTRIES))
    else $error("fill count beyond store depth");

  a_seen_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q >= $past(seen_q))
    else $error("seen count went backwards");

  a_write_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_DECIDE) || (state_q == ST_DIV)))
    else $error("tag write outside decision states");

  a_div_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (filled_q >= eff_cap) && (eff_cap != '0))
    else $error("remainder started while store not full");

endmodule

[bench/reservoir_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reservoir_checker
// watches the item, result and register ports of the reservoir sampler, keeps
// its own copy of the sampler state, predicts each result and compares it
// ----------------------------------------------------------------------------
module reservoir_checker #(
  parameter int unsigned SLOTS = hrs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hrs_in_if                             item_i,
  hrs_out_if                            result_i,
  input  logic                          cfg_we_i,
  input  logic [hrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hrs_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   outstanding_o
);
  import hrs_pkg::*;

  localparam logic [HASH_W-1:0] FNV_PRIME = 64'd1099511628211;

  typedef struct packed {
    logic              kind;
    logic              stored;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic [SEEN_W-1:0] seen;
    logic [CAP_W-1:0]  fill;
  } outcome_t;

  // sampler state as seen from outside
  logic [CAP_W-1:0]  capacity_q;
  logic [HASH_W-1:0] basis_q;
  logic [HASH_W-1:0] hash_q;
  logic [SEEN_W-1:0] seen_q;
  logic [CAP_W-1:0]  fill_q;
  logic [TAG_W-1:0]  tag_mem [SLOTS];

  outcome_t    expected_outcomes[$];
  int unsigned errors;

  task automatic sample_candidate();
    logic [HASH_W-1:0] folded;
    logic [HASH_W-1:0] pick;
    logic [CAP_W-1:0]  usable;
    outcome_t          res;
    res = '0;
    if (item_i.op == OP_READ) begin
      res.kind = KIND_READ;
      res.slot = item_i.read_slot;
      if (CAP_W'(item_i.read_slot) < fill_q) begin
        res.stored = 1'b1;
        res.tag    = tag_mem[item_i.read_slot];
      end
      res.seen = seen_q;
      res.fill = fill_q;
      expected_outcomes.insert(expected_outcomes.size(), res);
    end else begin
      folded = (hash_q ^ HASH_W'(item_i.id_char)) * FNV_PRIME;
      if (!item_i.id_last) begin
        hash_q = folded;
      end else begin
        hash_q = basis_q;
        if (seen_q != '1) seen_q++;
        usable = (capacity_q > SLOTS) ? CAP_W'(SLOTS) : capacity_q;
        res.kind = KIND_CAND;
        if (usable != '0) begin
          if (fill_q < usable) begin
            // still filling: append behind the last kept tag
            res.stored = 1'b1;
            res.slot   = SLOT_W'(fill_q);
            fill_q++;
          end else begin
            pick = folded % HASH_W'(seen_q);
            if (pick < HASH_W'(usable)) begin
              res.stored = 1'b1;
              res.slot   = SLOT_W'(pick);
            end
          end
        end
        if (res.stored) begin
          res.tag           = item_i.row_tag;
          tag_mem[res.slot] = item_i.row_tag;
        end
        res.seen = seen_q;
        res.fill = fill_q;
        expected_outcomes.insert(expected_outcomes.size(), res);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    outcome_t want;
    if (expected_outcomes.size() == 0) begin
      $error("result item with none expected: kind %0d slot %0d", result_i.kind,
             result_i.slot_index);
      errors++;
    end else begin
      want = expected_outcomes.pop_front();
      check_field("kind", 64'(want.kind), 64'(result_i.kind));
      check_field("stored", 64'(want.stored), 64'(result_i.stored));
      check_field("slot_index", 64'(want.slot), 64'(result_i.slot_index));
      check_field("slot_tag", 64'(want.tag), 64'(result_i.slot_tag));
      check_field("seen_total", 64'(want.seen), 64'(result_i.seen_total));
      check_field("fill_count", 64'(want.fill), 64'(result_i.fill_count));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      capacity_q = '0;
      basis_q    = BASIS_RESET;
      hash_q     = BASIS_RESET;
      seen_q     = '0;
      fill_q     = '0;
      errors     = 0;
      expected_outcomes.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAPACITY: capacity_q = cfg_wdata_i[CAP_W-1:0];
          REG_HASH_BASIS: begin
            basis_q = cfg_wdata_i;
            hash_q  = cfg_wdata_i;
          end
          default: ;
        endcase
      end
      if (result_i.valid && result_i.ready) check_result();
      if (item_i.valid && item_i.ready) sample_candidate();
    end
    fail_count_o  <= errors;
    outstanding_o <= expected_outcomes.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives identifier bytes and slot reads into the reservoir sampler across
// several capacity and hash basis settings; the checker beside the block
// predicts every result and counts mismatches, this module gives the verdict
// ----------------------------------------------------------------------------
module tb;
  import hrs_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 9;
  // longest item is a last byte with a full store
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned GAP_PCT       = 21;
  localparam int unsigned RUN_LIMIT_NS  = 5_000_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  // high while neither side may idle
  logic                 steady = 1'b0;
  int unsigned          fail_count;
  int unsigned          outstanding;
  int unsigned          sent_items = 0;

  hrs_in_if  item_ch ();
  hrs_out_if result_ch ();

  hashed_reservoir_sampler_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (item_ch),
    .out_o       (result_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  reservoir_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_ch),
    .result_i      (result_ch),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // result side stalls at random unless a steady stretch is running
  always @(posedge clk_i) begin
    result_ch.ready <= steady || ($urandom_range(99) >= GAP_PCT);
  end

  // one item on the input channel; valid stays high into the next item when
  // no gap is drawn, so it is never lowered and raised in the same step
  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic last, input logic [TAG_W-1:0] tag,
                           input logic [SLOT_W-1:0] slot);
    while (!steady && $urandom_range(99) < GAP_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid     <= 1'b1;
    item_ch.op        <= op;
    item_ch.id_char   <= ch;
    item_ch.id_last   <= last;
    item_ch.row_tag   <= tag;
    item_ch.read_slot <= slot;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    sent_items++;
  endtask

  // register writes only with the block idle: nothing outstanding, and time
  // for a trailing identifier byte that has no result of its own
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // read with junk in the unused fields; low slots half the time so reads
  // also hit filled slots while the store is still small
  task automatic send_read();
    logic [SLOT_W-1:0] slot;
    slot = ($urandom_range(1) == 0) ? SLOT_W'($urandom_range(7)) : SLOT_W'($urandom);
    send_item(OP_READ, CHAR_W'($urandom), 1'($urandom), TAG_W'($urandom), slot);
  endtask

  // mostly single-byte identifiers so the store fills in reasonable time,
  // the odd read slipped in between bytes
  task automatic send_candidate();
    int unsigned len;
    len = ($urandom_range(99) < 85) ? 1 : $urandom_range(6, 2);
    for (int unsigned k = 1; k <= len; k++) begin
      if ($urandom_range(99) < 5) send_read();
      send_item(OP_BYTE, CHAR_W'($urandom), k == len, TAG_W'($urandom), SLOT_W'($urandom));
    end
  endtask

  task automatic run_traffic(input int unsigned n_items, input int unsigned n_cands);
    int unsigned first_item;
    int unsigned cands;
    first_item = sent_items;
    cands      = 0;
    while (sent_items - first_item < n_items || cands < n_cands) begin
      if ($urandom_range(99) < 10) begin
        send_read();
      end else begin
        send_candidate();
        cands++;
      end
    end
    // sometimes leave a cut-off identifier for the next basis write to drop
    if ($urandom_range(1) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        send_item(OP_BYTE, CHAR_W'($urandom), 1'b0, TAG_W'($urandom), SLOT_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_CAPACITY;
    cfg_wdata_i       = '0;
    item_ch.valid     = 1'b0;
    item_ch.op        = OP_BYTE;
    item_ch.id_char   = '0;
    item_ch.id_last   = 1'b0;
    item_ch.row_tag   = '0;
    item_ch.read_slot = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // capacity zero after reset: candidates are only counted
    send_item(OP_BYTE, 8'h00, 1'b1, 16'hFFFF, 8'h00);
    send_item(OP_BYTE, 8'hFF, 1'b0, 16'h0000, 8'hFF);
    send_item(OP_BYTE, 8'hA5, 1'b0, 16'h1111, 8'h00);
    // read in the middle of an identifier must leave the hash alone
    send_item(OP_READ, 8'hFF, 1'b1, 16'hFFFF, 8'h00);
    send_item(OP_BYTE, 8'h5A, 1'b1, 16'h0000, 8'h00);
    // read beyond fill at the top slot
    send_item(OP_READ, 8'h00, 1'b0, 16'h0000, 8'hFF);

    // small store, zero basis: three appends, then replacements
    write_reg(REG_CAPACITY, CFG_W'(3));
    write_reg(REG_HASH_BASIS, '0);
    send_item(OP_BYTE, 8'hFF, 1'b1, 16'hFFFF, 8'h00);
    send_item(OP_BYTE, 8'h80, 1'b1, 16'h0000, 8'h00);
    send_item(OP_BYTE, 8'h01, 1'b1, 16'h8001, 8'h00);
    send_item(OP_BYTE, 8'h7F, 1'b0, 16'h0000, 8'h00);
    send_item(OP_BYTE, 8'h3C, 1'b1, 16'h1234, 8'h00);
    send_item(OP_BYTE, 8'h00, 1'b1, 16'hABCD, 8'h00);
    send_item(OP_READ, 8'h00, 1'b0, 16'h0000, 8'h00);
    send_item(OP_READ, 8'h00, 1'b0, 16'h0000, 8'h02);
    send_item(OP_READ, 8'h00, 1'b0, 16'h0000, 8'h03);
    // partial identifier, thrown away by the basis write below
    send_item(OP_BYTE, 8'h11, 1'b0, 16'h0000, 8'h00);
    send_item(OP_BYTE, 8'h22, 1'b0, 16'h0000, 8'h00);

    // capacity lowered below fill: replacement only, upper slots stay readable
    write_reg(REG_HASH_BASIS, '1);
    write_reg(REG_CAPACITY, CFG_W'(1));
    send_item(OP_BYTE, 8'h33, 1'b1, 16'h4321, 8'h00);
    send_item(OP_READ, 8'h00, 1'b0, 16'h0000, 8'h02);

    // capacity above the store size: appending resumes at the fill count
    write_reg(REG_CAPACITY, CFG_W'(511));
    send_item(OP_BYTE, 8'h44, 1'b1, 16'h5555, 8'h00);
    send_item(OP_READ, 8'h00, 1'b0, 16'h0000, 8'h03);

    // fill the whole store and keep going into replacement
    run_traffic(0, 260);

    // random capacity below the fill count
    write_reg(REG_CAPACITY, CFG_W'($urandom_range(255, 1)));
    write_reg(REG_HASH_BASIS, {$urandom, $urandom});
    run_traffic(25, 0);

    write_reg(REG_CAPACITY, '0);
    write_reg(REG_HASH_BASIS, '0);
    run_traffic(15, 0);

    // exact store size with no idling on either side
    write_reg(REG_CAPACITY, CFG_W'(256));
    write_reg(REG_HASH_BASIS, BASIS_RESET);
    steady <= 1'b1;
    run_traffic(50, 0);
    steady <= 1'b0;

    write_reg(REG_CAPACITY, CFG_W'(1));
    write_reg(REG_HASH_BASIS, {$urandom, $urandom});
    run_traffic(20, 0);

    // drain
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
